// ===== rtl/cascaded_reload_timer_bank_assert.svh =====
// Assertion macros for the timer bank RTL.
// Included by each module that checks its own logic; no other dependencies.
`ifndef CASCADED_RELOAD_TIMER_BANK_ASSERT_SVH
`define CASCADED_RELOAD_TIMER_BANK_ASSERT_SVH
`ifndef SYNTHESIS
`define CRB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("timer bank assertion failed");
`define CRB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank assertion failed");
`else
`define CRB_ASSERT(lbl, clk, rst, prop)
`define CRB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/crb_pkg.sv =====
// Shared types, constants and the prescaler period table of the timer bank.
// No dependencies.
package crb_pkg;

   localparam int CNT_W  = 16;
   localparam int PSC_W  = 10;
   localparam int PER_W  = PSC_W + 1;
   localparam int IDX_W  = 2;
   localparam int TYPE_W = 2;
   localparam int IRQ_W  = 4;

   // Control word bit positions.
   localparam int CTL_PSC_LO  = 0;
   localparam int CTL_PSC_HI  = 1;
   localparam int CTL_CASCADE = 2;
   localparam int CTL_IRQ     = 6;
   localparam int CTL_ENABLE  = 7;

   typedef enum logic [TYPE_W-1:0] {
      REQ_TICK    = 2'd0,
      REQ_RELOAD  = 2'd1,
      REQ_CONTROL = 2'd2,
      REQ_READ    = 2'd3
   } crb_req_code_type;

   typedef enum logic [1:0] {
      PSC_DIV1    = 2'd0,
      PSC_DIV64   = 2'd1,
      PSC_DIV256  = 2'd2,
      PSC_DIV1024 = 2'd3
   } crb_psc_code_type;

   // Command broadcast to every timer for one accepted word.
   typedef struct packed {
      logic             tick;
      logic             wr_reload;
      logic             wr_ctrl;
      logic [CNT_W-1:0] data;
   } crb_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] read_data;
      logic [IRQ_W-1:0] irq_pulse;
   } crb_rsp_type;

   function automatic logic [PER_W-1:0] period_of(input logic [1:0] sel);
      logic [PER_W-1:0] per;
      unique case (crb_psc_code_type'(sel))
         PSC_DIV1:    per = 11'd1;
         PSC_DIV64:   per = 11'd64;
         PSC_DIV256:  per = 11'd256;
         PSC_DIV1024: per = 11'd1024;
         default:     per = 11'd1024;
      endcase
      return per;
   endfunction

endpackage

// ===== rtl/crb_req_if.sv =====
// Request channel of the timer bank: valid/ready handshake and request word.
// Depends on crb_pkg for field widths.
interface crb_req_if;
   import crb_pkg::*;

   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [IDX_W-1:0]  timer_index;
   logic [CNT_W-1:0]  write_data;

   modport source(output valid, output req_type, output timer_index, output write_data,
                  input ready);
   modport sink(input valid, input req_type, input timer_index, input write_data,
                output ready);
endinterface

// ===== rtl/crb_rsp_if.sv =====
// Response channel of the timer bank: valid/ready handshake and result word.
// Depends on crb_pkg for field widths.
interface crb_rsp_if;
   import crb_pkg::*;

   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] read_data;
   logic [IRQ_W-1:0] irq_pulse;

   modport source(output valid, output read_data, output irq_pulse, input ready);
   modport sink(input valid, input read_data, input irq_pulse, output ready);
endinterface

// ===== rtl/crb_timer.sv =====
// One 16-bit reload timer with prescaler and cascade input.
// Depends on crb_pkg and the assertion macro header.
`include "cascaded_reload_timer_bank_assert.svh"

module crb_timer (
   input  logic                      clock,
   input  logic                      reset,
   input  crb_pkg::crb_cmd_type      cmd,
   input  logic                      sel,
   input  logic                      carry_in,
   output logic [crb_pkg::CNT_W-1:0] count,
   output logic                      carry_out,
   output logic                      irq
);
   import crb_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] reload_ff, reload_in;
   logic [PSC_W-1:0] psc_ff, psc_in;
   logic [1:0]       psel_ff, psel_in;
   logic             cascade_ff, cascade_in;
   logic             irq_en_ff, irq_en_in;
   logic             on_ff, on_in;

   logic [PER_W-1:0] psc_next;
   logic             expire;
   logic             adv;
   logic             ovf;

   assign psc_next = {1'b0, psc_ff} + PER_W'(1);
   assign expire   = psc_next >= period_of(psel_ff);
   assign adv      = cmd.tick && on_ff && (cascade_ff ? carry_in : expire);
   assign ovf      = adv && (count_ff == {CNT_W{1'b1}});

   always_comb begin
      count_in   = count_ff;
      reload_in  = reload_ff;
      psc_in     = psc_ff;
      psel_in    = psel_ff;
      cascade_in = cascade_ff;
      irq_en_in  = irq_en_ff;
      on_in      = on_ff;

      if (cmd.tick && on_ff && !cascade_ff) begin
         psc_in = expire ? '0 : psc_next[PSC_W-1:0];
      end
      if (adv) begin
         count_in = ovf ? reload_ff : count_ff + CNT_W'(1);
      end
      if (sel && cmd.wr_reload) begin
         reload_in = cmd.data;
      end
      if (sel && cmd.wr_ctrl) begin
         psel_in    = cmd.data[CTL_PSC_HI:CTL_PSC_LO];
         cascade_in = cmd.data[CTL_CASCADE];
         irq_en_in  = cmd.data[CTL_IRQ];
         on_in      = cmd.data[CTL_ENABLE];
         // Turning the timer on restarts it from the reload value.
         if (!on_ff && cmd.data[CTL_ENABLE]) begin
            count_in = reload_ff;
            psc_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         reload_ff  <= '0;
         psc_ff     <= '0;
         psel_ff    <= '0;
         cascade_ff <= 1'b0;
         irq_en_ff  <= 1'b0;
         on_ff      <= 1'b0;
      end else begin
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         psc_ff     <= psc_in;
         psel_ff    <= psel_in;
         cascade_ff <= cascade_in;
         irq_en_ff  <= irq_en_in;
         on_ff      <= on_in;
      end
   end

   assign count     = count_ff;
   assign carry_out = ovf;
   assign irq       = ovf && irq_en_ff;

   `CRB_ASSERT_NEXT(a_enable_loads, clock, reset,
      sel && cmd.wr_ctrl && !on_ff && cmd.data[CTL_ENABLE], count_ff == $past(reload_ff))
   `CRB_ASSERT_NEXT(a_ovf_reloads, clock, reset, ovf, count_ff == $past(reload_ff))
   `CRB_ASSERT_NEXT(a_off_holds, clock, reset, !on_ff && !(sel && cmd.wr_ctrl),
      $stable(count_ff) && $stable(psc_ff))

endmodule

// ===== rtl/cascaded_reload_timer_bank.sv =====
// Bank of NUM_TIMERS cascadable 16-bit reload timers. Each request word (tick,
// reload write, control write or count read) gives exactly one registered
// response word; a new request may enter every cycle while ready is high. The
// longest path is the overflow ripple from the lowest timer through all
// NUM_TIMERS counters within the tick. A two-word response buffer keeps the
// request side open while one response waits; ready falls only when both
// words are held. Only timers 0 to 3 are addressable and report interrupt
// bits.
`include "cascaded_reload_timer_bank_assert.svh"

module cascaded_reload_timer_bank #(
   parameter int NUM_TIMERS = 4
) (
   input logic clock,
   input logic reset,
   crb_req_if.sink   req_ch,
   crb_rsp_if.source rsp_ch
);
   import crb_pkg::*;

   logic             accept;
   crb_req_code_type code;
   crb_cmd_type      cmd;

   logic [NUM_TIMERS:0]   carry;
   logic [NUM_TIMERS-1:0] irq_all;
   logic [NUM_TIMERS-1:0] sel;
   logic [CNT_W-1:0]      counts [NUM_TIMERS];
   logic [NUM_TIMERS+IRQ_W-1:0] irq_pad;

   logic [CNT_W-1:0] rd;
   crb_rsp_type      rsp_new;

   crb_rsp_type out_ff, out_in, skid_ff, skid_in;
   logic        out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic        rsp_fire;

   assign req_ch.ready = !skid_v_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign code         = crb_req_code_type'(req_ch.req_type);

   always_comb begin
      cmd.tick      = 1'b0;
      cmd.wr_reload = 1'b0;
      cmd.wr_ctrl   = 1'b0;
      cmd.data      = req_ch.write_data;
      if (accept) begin
         unique case (code)
            REQ_TICK:    cmd.tick      = 1'b1;
            REQ_RELOAD:  cmd.wr_reload = 1'b1;
            REQ_CONTROL: cmd.wr_ctrl   = 1'b1;
            REQ_READ:    ;
            default:     ;
         endcase
      end
   end

   assign carry[0] = 1'b0;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
      // Timers above the index range cannot be selected.
      if (i < IRQ_W) begin : g_addr
         assign sel[i] = (req_ch.timer_index == IDX_W'(i));
      end else begin : g_noaddr
         assign sel[i] = 1'b0;
      end

      crb_timer u_timer (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel       (sel[i]),
         .carry_in  (carry[i]),
         .count     (counts[i]),
         .carry_out (carry[i+1]),
         .irq       (irq_all[i])
      );
   end

   assign irq_pad = {{IRQ_W{1'b0}}, irq_all};

   always_comb begin
      rd = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (sel[i]) begin
            rd = counts[i];
         end
      end
      rsp_new.read_data = (code == REQ_READ) ? rd : '0;
      rsp_new.irq_pulse = (code == REQ_TICK) ? irq_pad[IRQ_W-1:0] : '0;
   end

   // Two-word response buffer: the skid word only fills when the output
   // word is stalled at the moment a new request is taken.
   assign rsp_fire = out_v_ff && rsp_ch.ready;

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (rsp_fire) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_v_ff || rsp_fire) begin
            out_in   = rsp_new;
            out_v_in = 1'b1;
         end else begin
            skid_in   = rsp_new;
            skid_v_in = 1'b1;
         end
      end else if (rsp_fire) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.read_data = out_ff.read_data;
   assign rsp_ch.irq_pulse = out_ff.irq_pulse;

   `CRB_ASSERT(a_skid_needs_out, clock, reset, !skid_v_ff || out_v_ff)
   `CRB_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      accept && out_v_ff && !rsp_ch.ready, skid_v_ff && out_v_ff)
   `CRB_ASSERT_NEXT(a_drain_empties, clock, reset,
      rsp_fire && !skid_v_ff && !accept, !out_v_ff)

endmodule
